// ===== src/rrcp_pkg.sv =====
`default_nettype none

package rrcp_pkg;

  // Fixed-point constants for the corner arc angles and unity (Q2.30).
  localparam longint unsigned PiQ30  = 64'd3373259426;
  localparam longint unsigned OneQ30 = 64'd1073741824;

  // One cross-section as it arrives on the input channel.
  typedef struct packed {
    logic [9:0]  section_id;
    logic [30:0] width;
    logic [30:0] height;
    logic [30:0] axis_a0;
    logic [30:0] axis_b0;
    logic [30:0] axis_a1;
    logic [30:0] axis_b1;
    logic [30:0] axis_a2;
    logic [30:0] axis_b2;
    logic [30:0] axis_a3;
    logic [30:0] axis_b3;
  } in_item_t;

  // One outline point as it leaves on the result channel.
  typedef struct packed {
    logic [9:0]         section_tag;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [5:0]         point_index;
    logic [1:0]         corner;
    logic               corner_first;
    logic               corner_last;
    logic               last;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGE,
    ST_ARC,
    ST_CLOSE
  } ctrl_state_t;

  // Kind of point the datapath is asked to build.
  typedef enum logic [1:0] {
    PT_EDGE,
    PT_ARC,
    PT_CLOSE
  } point_kind_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic        load;
    logic        issue;
    point_kind_t kind;
    logic [1:0]  corner;
    logic        first;
    logic        last_c;
    logic        last;
    logic [5:0]  index;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       advance;
    logic [3:0] arc_on;
  } dp_status_t;

  // Clamp a series sum to the range [0, 1] in Q2.30.
  function automatic logic [30:0] clamp_q30(input longint v);
    logic [30:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > longint'(OneQ30)) begin
      res = 31'(OneQ30);
    end else begin
      res = 31'(v);
    end
    return res;
  endfunction

  // Sine of a Q2.30 angle by a truncated Taylor series (evaluated at elaboration).
  function automatic logic [30:0] sin_q30(input longint unsigned t);
    longint unsigned t2;
    longint unsigned ts;
    longint          s;
    t2 = (t * t) >> 30;
    ts = t;
    s  = longint'(t);
    ts = ((ts * t2) >> 30) / 6;   s = s - longint'(ts);
    ts = ((ts * t2) >> 30) / 20;  s = s + longint'(ts);
    ts = ((ts * t2) >> 30) / 42;  s = s - longint'(ts);
    ts = ((ts * t2) >> 30) / 72;  s = s + longint'(ts);
    ts = ((ts * t2) >> 30) / 110; s = s - longint'(ts);
    ts = ((ts * t2) >> 30) / 156; s = s + longint'(ts);
    ts = ((ts * t2) >> 30) / 210; s = s - longint'(ts);
    ts = ((ts * t2) >> 30) / 272; s = s + longint'(ts);
    return clamp_q30(s);
  endfunction

  // Cosine of a Q2.30 angle by a truncated Taylor series (evaluated at elaboration).
  function automatic logic [30:0] cos_q30(input longint unsigned t);
    longint unsigned t2;
    longint unsigned tc;
    longint          c;
    t2 = (t * t) >> 30;
    tc = OneQ30;
    c  = longint'(OneQ30);
    tc = ((tc * t2) >> 30) / 2;   c = c - longint'(tc);
    tc = ((tc * t2) >> 30) / 12;  c = c + longint'(tc);
    tc = ((tc * t2) >> 30) / 30;  c = c - longint'(tc);
    tc = ((tc * t2) >> 30) / 56;  c = c + longint'(tc);
    tc = ((tc * t2) >> 30) / 90;  c = c - longint'(tc);
    tc = ((tc * t2) >> 30) / 132; c = c + longint'(tc);
    tc = ((tc * t2) >> 30) / 182; c = c - longint'(tc);
    tc = ((tc * t2) >> 30) / 240; c = c + longint'(tc);
    return clamp_q30(c);
  endfunction

endpackage

`default_nettype wire

// ===== src/rrcp_stream_if.sv =====
`default_nettype none

// Valid/ready stream channel; a transfer happens when valid and ready are both high.
interface rrcp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/rrcp_ctrl.sv =====
`default_nettype none

module rrcp_ctrl #(
  parameter int ARC_STEPS = 10,
  localparam int KW = $clog2(ARC_STEPS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rrcp_pkg::dp_status_t status,
  output rrcp_pkg::dp_cmd_t    cmd,
  output logic [KW-1:0]        k
);

  rrcp_pkg::ctrl_state_t state_r, state_nxt;
  logic [1:0]    corner_r, corner_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [5:0]    idx_r, idx_nxt;
  logic          arc_here;

  assign arc_here = status.arc_on[corner_r];

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rrcp_pkg::ST_IDLE;
      corner_r <= '0;
      k_r      <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
      k_r      <= k_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // Next state: walk edge, arc and closing points corner by corner.
  always_comb begin
    state_nxt  = state_r;
    corner_nxt = corner_r;
    k_nxt      = k_r;
    idx_nxt    = idx_r;
    case (state_r)
      rrcp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt  = rrcp_pkg::ST_EDGE;
          corner_nxt = '0;
          idx_nxt    = '0;
        end
      end
      rrcp_pkg::ST_EDGE: begin
        if (status.advance) begin
          idx_nxt = idx_r + 6'd1;
          if (arc_here) begin
            state_nxt = rrcp_pkg::ST_ARC;
            k_nxt     = KW'(1);
          end else if (corner_r == 2'd3) begin
            state_nxt = rrcp_pkg::ST_IDLE;
          end else begin
            corner_nxt = corner_r + 2'd1;
          end
        end
      end
      rrcp_pkg::ST_ARC: begin
        if (status.advance) begin
          idx_nxt = idx_r + 6'd1;
          if (k_r == KW'(ARC_STEPS - 1)) begin
            state_nxt = rrcp_pkg::ST_CLOSE;
          end else begin
            k_nxt = k_r + KW'(1);
          end
        end
      end
      rrcp_pkg::ST_CLOSE: begin
        if (status.advance) begin
          idx_nxt = idx_r + 6'd1;
          if (corner_r == 2'd3) begin
            state_nxt = rrcp_pkg::ST_IDLE;
          end else begin
            state_nxt  = rrcp_pkg::ST_EDGE;
            corner_nxt = corner_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = rrcp_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: handshake and point command.
  always_comb begin
    in_ready   = (state_r == rrcp_pkg::ST_IDLE);
    cmd.load   = (state_r == rrcp_pkg::ST_IDLE) && in_valid;
    cmd.issue  = (state_r != rrcp_pkg::ST_IDLE) && status.advance;
    cmd.corner = corner_r;
    cmd.index  = idx_r;
    cmd.first  = 1'b0;
    cmd.last_c = 1'b0;
    cmd.kind   = rrcp_pkg::PT_EDGE;
    case (state_r)
      rrcp_pkg::ST_EDGE: begin
        cmd.kind   = rrcp_pkg::PT_EDGE;
        cmd.first  = 1'b1;
        cmd.last_c = !arc_here;
      end
      rrcp_pkg::ST_ARC: begin
        cmd.kind = rrcp_pkg::PT_ARC;
      end
      rrcp_pkg::ST_CLOSE: begin
        cmd.kind   = rrcp_pkg::PT_CLOSE;
        cmd.last_c = 1'b1;
      end
      default: begin
        cmd.kind = rrcp_pkg::PT_EDGE;
      end
    endcase
    cmd.last = cmd.last_c && (corner_r == 2'd3);
    k        = k_r;
  end

endmodule

`default_nettype wire

// ===== src/rrcp_dp.sv =====
`default_nettype none

module rrcp_dp #(
  parameter int ARC_STEPS = 10,
  localparam int KW = $clog2(ARC_STEPS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rrcp_pkg::in_item_t   in_item,
  input  rrcp_pkg::dp_cmd_t    cmd,
  input  logic [KW-1:0]        k,
  output rrcp_pkg::dp_status_t status,
  output rrcp_pkg::out_item_t  out_item,
  output logic                 out_valid,
  input  logic                 out_ready
);

  // Point attributes carried alongside the arithmetic.
  typedef struct packed {
    logic [9:0] section_tag;
    logic [5:0] point_index;
    logic [1:0] corner;
    logic       corner_first;
    logic       corner_last;
    logic       last;
  } pt_tag_t;

  // Saturate a widened coordinate to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] res;
    if (v > 34'sh0_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      res = -32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Cosine and sine table for the interior arc angles.
  logic [30:0] cos_tab [ARC_STEPS];
  logic [30:0] sin_tab [ARC_STEPS];

  for (genvar gk = 0; gk < ARC_STEPS; gk++) begin : g_trig
    localparam longint unsigned Ang =
      (longint'(gk) * rrcp_pkg::PiQ30 + longint'(ARC_STEPS)) / longint'(2 * ARC_STEPS);
    assign cos_tab[gk] = rrcp_pkg::cos_q30(Ang);
    assign sin_tab[gk] = rrcp_pkg::sin_q30(Ang);
  end

  rrcp_pkg::in_item_t in_r;

  logic               advance;
  logic               a_vld_r, b_vld_r, c_vld_r, out_vld_r;
  logic signed [31:0] a_base_x_r, a_base_y_r;
  logic [30:0]        a_mx_r, a_my_r, a_fx_r, a_fy_r;
  pt_tag_t            a_tag_r;
  logic signed [31:0] b_base_x_r, b_base_y_r;
  logic [61:0]        b_px_r, b_py_r;
  logic               b_nx_r, b_ny_r;
  pt_tag_t            b_tag_r;
  logic signed [31:0] c_base_x_r, c_base_y_r;
  logic [31:0]        c_ex_r, c_ey_r;
  logic               c_nx_r, c_ny_r;
  pt_tag_t            c_tag_r;
  logic               a_nx_r, a_ny_r;
  rrcp_pkg::out_item_t out_r;

  logic [29:0]        hw, hh;
  logic [30:0]        a_sel, b_sel;
  logic               sx_neg, sy_neg, even;
  logic signed [31:0] dx, dy, cx, cy, hwx, hhy;
  logic signed [31:0] base_x, base_y;
  logic [30:0]        fx, fy;
  pt_tag_t            tag;
  logic signed [33:0] ex_s, ey_s, sum_x, sum_y;

  // The whole pipeline moves when the output register is free or being emptied.
  assign advance        = !out_vld_r || out_ready;
  assign status.advance = advance;
  assign status.arc_on  = {in_r.axis_b3 != '0, in_r.axis_a2 != '0,
                           in_r.axis_b1 != '0, in_r.axis_a0 != '0};

  // Capture the section on the input transfer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
    end
  end

  // Corner geometry: semi-axes, arc center and the straight-edge coordinates.
  always_comb begin
    case (cmd.corner)
      2'd0:    begin a_sel = in_r.axis_a0; b_sel = in_r.axis_b0; end
      2'd1:    begin a_sel = in_r.axis_a1; b_sel = in_r.axis_b1; end
      2'd2:    begin a_sel = in_r.axis_a2; b_sel = in_r.axis_b2; end
      default: begin a_sel = in_r.axis_a3; b_sel = in_r.axis_b3; end
    endcase
    hw     = in_r.width[30:1];
    hh     = in_r.height[30:1];
    sx_neg = (cmd.corner == 2'd1) || (cmd.corner == 2'd2);
    sy_neg = cmd.corner[1];
    even   = !cmd.corner[0];
    dx     = $signed({2'b00, hw}) - $signed({1'b0, a_sel});
    dy     = $signed({2'b00, hh}) - $signed({1'b0, b_sel});
    cx     = sx_neg ? -dx : dx;
    cy     = sy_neg ? -dy : dy;
    hwx    = sx_neg ? -$signed({2'b00, hw}) : $signed({2'b00, hw});
    hhy    = sy_neg ? -$signed({2'b00, hh}) : $signed({2'b00, hh});
  end

  // Select the point's base and the trig factors; straight points use a zero factor.
  always_comb begin
    base_x = cx;
    base_y = cy;
    fx     = '0;
    fy     = '0;
    case (cmd.kind)
      rrcp_pkg::PT_EDGE: begin
        base_x = even ? hwx : cx;
        base_y = even ? cy : hhy;
      end
      rrcp_pkg::PT_CLOSE: begin
        base_x = even ? cx : hwx;
        base_y = even ? hhy : cy;
      end
      rrcp_pkg::PT_ARC: begin
        fx = even ? cos_tab[k] : sin_tab[k];
        fy = even ? sin_tab[k] : cos_tab[k];
      end
      default: begin
        base_x = cx;
        base_y = cy;
      end
    endcase
    tag.section_tag  = in_r.section_id;
    tag.point_index  = cmd.index;
    tag.corner       = cmd.corner;
    tag.corner_first = cmd.first;
    tag.corner_last  = cmd.last_c;
    tag.last         = cmd.last;
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      a_vld_r   <= cmd.issue;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      out_vld_r <= c_vld_r;
    end
  end

  // Final add and saturation into the output register.
  always_comb begin
    ex_s  = $signed({2'b00, c_ex_r});
    ey_s  = $signed({2'b00, c_ey_r});
    sum_x = $signed({{2{c_base_x_r[31]}}, c_base_x_r}) + (c_nx_r ? -ex_s : ex_s);
    sum_y = $signed({{2{c_base_y_r[31]}}, c_base_y_r}) + (c_ny_r ? -ey_s : ey_s);
  end

  // Operand, multiply, round and output stages.
  always_ff @(posedge clk) begin
    if (advance) begin
      a_base_x_r <= base_x;
      a_base_y_r <= base_y;
      a_mx_r     <= a_sel;
      a_my_r     <= b_sel;
      a_fx_r     <= fx;
      a_fy_r     <= fy;
      a_nx_r     <= sx_neg;
      a_ny_r     <= sy_neg;
      a_tag_r    <= tag;

      b_px_r     <= a_mx_r * a_fx_r;
      b_py_r     <= a_my_r * a_fy_r;
      b_base_x_r <= a_base_x_r;
      b_base_y_r <= a_base_y_r;
      b_nx_r     <= a_nx_r;
      b_ny_r     <= a_ny_r;
      b_tag_r    <= a_tag_r;

      c_ex_r     <= 32'((b_px_r + 62'h2000_0000) >> 30);
      c_ey_r     <= 32'((b_py_r + 62'h2000_0000) >> 30);
      c_base_x_r <= b_base_x_r;
      c_base_y_r <= b_base_y_r;
      c_nx_r     <= b_nx_r;
      c_ny_r     <= b_ny_r;
      c_tag_r    <= b_tag_r;

      out_r.section_tag  <= c_tag_r.section_tag;
      out_r.point_x      <= sat32(sum_x);
      out_r.point_y      <= sat32(sum_y);
      out_r.point_index  <= c_tag_r.point_index;
      out_r.corner       <= c_tag_r.corner;
      out_r.corner_first <= c_tag_r.corner_first;
      out_r.corner_last  <= c_tag_r.corner_last;
      out_r.last         <= c_tag_r.last;
    end
  end

  assign out_item  = out_r;
  assign out_valid = out_vld_r;

endmodule

`default_nettype wire

// ===== src/rounded_rect_contour_points_unit.sv =====
`default_nettype none

// Rounded-rectangle outline generator. Each input transfer carries one
// cross-section (width, height and the two semi-axes of each corner arc) and
// produces its outline as a stream of points, corner by corner from right-top
// counterclockwise: an edge point per corner, plus ARC_STEPS-1 interior arc
// points and a closing point for each corner whose arc is present, so 4 to
// 4*(ARC_STEPS+1) points per section. Points leave at one per cycle while the
// result side is ready; the sequencer issues one point per cycle, while the
// output register is free or being emptied, into a four-stage
// operand/multiply/round/add pipeline. A new section is taken the cycle after
// the last point of the previous one has been issued. Coordinates are signed
// Q15.16 and saturate at the 32-bit limits; point_index counts modulo 64.
module rounded_rect_contour_points_unit #(
  parameter int ARC_STEPS = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  rrcp_stream_if.sink   in_ch,
  rrcp_stream_if.source out_ch
);

  localparam int KW = $clog2(ARC_STEPS);

  rrcp_pkg::dp_cmd_t    cmd;
  rrcp_pkg::dp_status_t status;
  logic [KW-1:0]        k;
  rrcp_pkg::in_item_t   in_item;
  rrcp_pkg::out_item_t  out_item;

  assign in_item     = in_ch.data;
  assign out_ch.data = out_item;

  // Sequencer over corners and arc steps.
  rrcp_ctrl #(
    .ARC_STEPS (ARC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd),
    .k        (k)
  );

  // Point arithmetic and output register.
  rrcp_dp #(
    .ARC_STEPS (ARC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .k         (k),
    .status    (status),
    .out_item  (out_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

endmodule

`default_nettype wire

// ===== src/rrcp_checker.sv =====
`default_nettype none

module rrcp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rrcp_pkg::out_item_t out_item
);

  // A pending point is not withdrawn before its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped without a transfer");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The final point of a section closes the right-bottom corner.
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> out_item.corner == 2'd3 && out_item.corner_last)
    else $error("section end outside the closing point of the last corner");

  // The outline starts with the right-top edge point and never ends there.
  a_first_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.point_index == 6'd0 |->
      out_item.corner == 2'd0 && out_item.corner_first && !out_item.last)
    else $error("outline does not start at the right-top edge point");

  // Ready is a clean level whenever a section is offered.
  a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_ready))
    else $error("input ready unknown");

endmodule

bind rounded_rect_contour_points_unit rrcp_checker u_rrcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.data)
);

`default_nettype wire
